// ===== rtl/stbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table package
// Types, codes and defaults shared by the sorted table controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stbl_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ITEM_WIDTH_DEF = 32;

  // Request codes.
  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_DELETE    = 3'd1;
  localparam logic [2:0] REQ_LOOKUP    = 3'd2;
  localparam logic [2:0] REQ_REWIND    = 3'd3;
  localparam logic [2:0] REQ_READ_NEXT = 3'd4;
  localparam logic [2:0] REQ_CLEAR     = 3'd5;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_AT_END    = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic [6:0]  entry_total;
    logic        at_end;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_SEARCH,
    S_DEL_SHIFT,
    S_RD_WAIT
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Read address relative to the next index value, or the read cursor.
  typedef enum logic [1:0] {
    RD_NEXT_M1,
    RD_NEXT,
    RD_NEXT_P1,
    RD_CURSOR
  } rd_sel_e;

  typedef struct packed {
    logic       v_load;
    idx_op_e    idx_op;
    rd_sel_e    rd_sel;
    logic       wr_en;
    logic       wr_from_v;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       cur_clr;
    logic       cur_inc;
    logic       rsp_en;
    logic [1:0] rsp_status;
    logic       rsp_item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cur_at_end;
    logic idx_zero;
    logic idx_at_count;
    logic idx_last;
    logic rd_lt;
    logic rd_eq;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/stbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted table controller
// Sequences each request over the datapath: top-down shift for insert,
// forward search for lookup and delete, then the downward shift of delete.
// ----------------------------------------------------------------------------
`default_nettype none

module stbl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic [2:0]     req_type_i,
  input  wire stbl_pkg::sts_t sts_i,
  output stbl_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  stbl_pkg::state_e state_q, state_d;
  logic             del_q, del_d;
  logic             found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbl_pkg::S_IDLE;
      del_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      del_q   <= del_d;
    end
  end

  assign found = !sts_i.idx_at_count && sts_i.rd_eq;

  always_comb begin
    state_d           = state_q;
    del_d             = del_q;
    cmd_o             = '0;
    cmd_o.idx_op      = stbl_pkg::IDX_HOLD;
    cmd_o.rd_sel      = stbl_pkg::RD_NEXT;
    cmd_o.rsp_status  = stbl_pkg::STAT_OK;
    busy_o            = 1'b1;

    unique case (state_q)
      stbl_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start) begin
          cmd_o.v_load = 1'b1;
          unique case (req_type_i)
            stbl_pkg::REQ_INSERT: begin
              if (sts_i.full) begin
                cmd_o.rsp_en     = 1'b1;
                cmd_o.rsp_status = stbl_pkg::STAT_FULL;
              end else begin
                cmd_o.idx_op = stbl_pkg::IDX_COUNT;
                cmd_o.rd_sel = stbl_pkg::RD_NEXT_M1;
                state_d      = stbl_pkg::S_INS_WALK;
              end
            end
            stbl_pkg::REQ_DELETE, stbl_pkg::REQ_LOOKUP: begin
              cmd_o.idx_op = stbl_pkg::IDX_ZERO;
              cmd_o.rd_sel = stbl_pkg::RD_NEXT;
              del_d        = (req_type_i == stbl_pkg::REQ_DELETE);
              state_d      = stbl_pkg::S_SEARCH;
            end
            stbl_pkg::REQ_REWIND: begin
              cmd_o.cur_clr = 1'b1;
              cmd_o.rsp_en  = 1'b1;
            end
            stbl_pkg::REQ_READ_NEXT: begin
              if (sts_i.cur_at_end) begin
                cmd_o.rsp_en     = 1'b1;
                cmd_o.rsp_status = stbl_pkg::STAT_AT_END;
              end else begin
                cmd_o.rd_sel = stbl_pkg::RD_CURSOR;
                state_d      = stbl_pkg::S_RD_WAIT;
              end
            end
            stbl_pkg::REQ_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              cmd_o.cur_clr = 1'b1;
              cmd_o.rsp_en  = 1'b1;
            end
            default: begin
              cmd_o.rsp_en = 1'b1;
            end
          endcase
        end
      end

      // Walk down from the top: entries not smaller than the new item move up one
      // place until the slot for the new item is reached.
      stbl_pkg::S_INS_WALK: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.idx_zero || sts_i.rd_lt) begin
          cmd_o.wr_from_v = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.cur_clr   = 1'b1;
          cmd_o.rsp_en    = 1'b1;
          state_d         = stbl_pkg::S_IDLE;
        end else begin
          cmd_o.idx_op = stbl_pkg::IDX_DEC;
          cmd_o.rd_sel = stbl_pkg::RD_NEXT_M1;
        end
      end

      stbl_pkg::S_SEARCH: begin
        if (sts_i.idx_at_count || !sts_i.rd_lt) begin
          if (del_q && found) begin
            cmd_o.rd_sel = stbl_pkg::RD_NEXT_P1;
            state_d      = stbl_pkg::S_DEL_SHIFT;
          end else begin
            cmd_o.rsp_en     = 1'b1;
            cmd_o.rsp_item   = found;
            cmd_o.rsp_status = found ? stbl_pkg::STAT_OK : stbl_pkg::STAT_NOT_FOUND;
            state_d          = stbl_pkg::S_IDLE;
          end
        end else begin
          cmd_o.idx_op = stbl_pkg::IDX_INC;
          cmd_o.rd_sel = stbl_pkg::RD_NEXT;
        end
      end

      stbl_pkg::S_DEL_SHIFT: begin
        if (sts_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.cur_clr = 1'b1;
          cmd_o.rsp_en  = 1'b1;
          state_d       = stbl_pkg::S_IDLE;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.idx_op = stbl_pkg::IDX_INC;
          cmd_o.rd_sel = stbl_pkg::RD_NEXT_P1;
        end
      end

      stbl_pkg::S_RD_WAIT: begin
        cmd_o.cur_inc  = 1'b1;
        cmd_o.rsp_en   = 1'b1;
        cmd_o.rsp_item = 1'b1;
        state_d        = stbl_pkg::S_IDLE;
      end

      default: begin
        state_d = stbl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/stbl_dpath.sv =====
// ----------------------------------------------------------------------------
// Sorted table datapath
// Entry memory, index, count and cursor registers, the comparator and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbl_dpath #(
  parameter int DEPTH      = stbl_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = stbl_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stbl_pkg::cmd_t cmd_i,
  input  wire logic [31:0]    item_value_i,
  output stbl_pkg::sts_t      sts_o,
  output stbl_pkg::rsp_t      rsp_o,
  output logic                done_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  logic [ITEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ITEM_WIDTH-1:0] rdata_q;
  logic [ITEM_WIDTH-1:0] value_q;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       cursor_q, cursor_d;
  logic [CntW-1:0]       rd_ptr;
  logic [AddrW-1:0]      rd_addr;
  logic [AddrW-1:0]      wr_addr;
  logic [CntW:0]         idx_plus1;
  stbl_pkg::rsp_t        rsp_d, rsp_q;
  logic                  done_q;

  always_comb begin
    unique case (cmd_i.idx_op)
      stbl_pkg::IDX_ZERO:  idx_d = '0;
      stbl_pkg::IDX_COUNT: idx_d = count_q;
      stbl_pkg::IDX_INC:   idx_d = idx_q + 1'b1;
      stbl_pkg::IDX_DEC:   idx_d = idx_q - 1'b1;
      default:             idx_d = idx_q;
    endcase
  end

  // Addresses outside the table are only issued when the data goes unused.
  always_comb begin
    unique case (cmd_i.rd_sel)
      stbl_pkg::RD_NEXT_M1: rd_ptr = idx_d - 1'b1;
      stbl_pkg::RD_NEXT_P1: rd_ptr = idx_d + 1'b1;
      stbl_pkg::RD_CURSOR:  rd_ptr = cursor_q;
      default:              rd_ptr = idx_d;
    endcase
  end

  assign rd_addr = rd_ptr[AddrW-1:0];
  assign wr_addr = idx_q[AddrW-1:0];
  assign wr_data = cmd_i.wr_from_v ? value_q : rdata_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.cur_clr) begin
      cursor_d = '0;
    end else if (cmd_i.cur_inc) begin
      cursor_d = cursor_q + 1'b1;
    end
  end

  always_comb begin
    rsp_d.status      = cmd_i.rsp_status;
    rsp_d.item_out    = cmd_i.rsp_item ? 32'(rdata_q) : '0;
    rsp_d.entry_total = 7'(count_d);
    rsp_d.at_end      = (cursor_d >= count_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.v_load) begin
      value_q <= ITEM_WIDTH'(item_value_i);
    end
    if (cmd_i.rsp_en) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= cmd_i.rsp_en;
    end
  end

  assign idx_plus1 = {1'b0, idx_q} + 1'b1;

  assign sts_o.full         = (count_q == DepthCnt);
  assign sts_o.cur_at_end   = (cursor_q >= count_q);
  assign sts_o.idx_zero     = (idx_q == '0);
  assign sts_o.idx_at_count = (idx_q == count_q);
  assign sts_o.idx_last     = (idx_plus1 >= {1'b0, count_q});
  assign sts_o.rd_lt        = (rdata_q < value_q);
  assign sts_o.rd_eq        = (rdata_q == value_q);

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted table engine
// Ascending table of up to DEPTH items held in a shifted array, with insert,
// delete, lookup, cursor read, rewind and clear requests.
//
//   Channel   Ports                 Handshake
//   request   req_i                 taken when start is high and busy is low
//   result    rsp_o                 valid for one cycle while done_o is high
//
// Rewind, clear, unused codes, insert into a full table and read past the end
// give their result in the cycle after acceptance; read next passes through
// a read wait state first. Insert walks down from the count to the slot of
// the new item, lookup searches up from the first entry, and delete adds
// a downward shift from the found entry to the end of the table.
// busy is low only in the idle state; a new request may be taken in the cycle
// that carries the previous result. Reset empties the table and rewinds the
// cursor; the entry memory itself is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_engine #(
  parameter int DEPTH      = stbl_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = stbl_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire stbl_pkg::req_t req_i,
  output stbl_pkg::rsp_t      rsp_o,
  output logic                done_o
);

  localparam logic [6:0] DepthTotal = 7'(DEPTH);

  stbl_pkg::cmd_t cmd;
  stbl_pkg::sts_t sts;

  stbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  stbl_dpath #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_value_i (req_i.item_value),
    .sts_o        (sts),
    .rsp_o        (rsp_o),
    .done_o       (done_o)
  );

  // A result only ever follows an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !done_o)
    else $error("result strobe without an accepted item");

  // A full status is reported only when the table holds DEPTH entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == stbl_pkg::STAT_FULL |-> rsp_o.entry_total == DepthTotal)
    else $error("full status with table not full");

  // A read past the end carries no item and flags the cursor at the end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == stbl_pkg::STAT_AT_END |-> rsp_o.at_end && rsp_o.item_out == '0)
    else $error("read past end with item or cursor not at end");

  // The table count never passes its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.full |=> !cmd.cnt_inc)
    else $error("entry count grew beyond the table depth");

endmodule

`default_nettype wire
